FILE: hdl/ilist_pkg.sv
// ----------------------------------------------------------------------------
// ilist_pkg: shared types and codes for the indexed list unit
// Operation and status codes plus the request and response payload structs.
// ----------------------------------------------------------------------------
package ilist_pkg;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int CNT_W   = 5;

  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_READ      = 3'd1;
  localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND      = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_V  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  data;
    logic [POS_W-1:0]  position;
    logic              found;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
    logic              full_res;
  } rsp_t;

endpackage

FILE: hdl/ilist_stream_if.sv
// ----------------------------------------------------------------------------
// ilist_stream_if: valid/ready stream channel
// Carries one payload of type T; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ilist_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/indexed_list_insert_remove_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_unit: fixed-capacity ordered list store
// Each request passes through execute, then an optional read, shift walk or
// search walk over the entry RAM, then done; overwrite and any bad index, full
// or empty-search case go from execute straight to done. Insert shifts entries
// up from the top, remove shifts them down, and find walks from entry 0.
// Done holds until the output register is free. Ready returns as the response
// loads, so a new request waits for the last response. Reset clears the count and control; entries hold.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_unit #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  ilist_stream_if.sink          req,
  ilist_stream_if.source        rsp
);
  import ilist_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_RD   = 7'b0000100,
    S_UP   = 7'b0001000,
    S_DOWN = 7'b0010000,
    S_SRCH = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [WIDTH-1:0] wr_data;

  logic [OP_W-1:0]   op;
  logic [CMPW-1:0]   idx;
  logic [WIDTH-1:0]  val;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [WIDTH-1:0]  res_data, res_data_next;
  logic [POS_W-1:0]  res_pos, res_pos_next;
  logic              res_found, res_found_next;

  logic          accept, out_load;
  logic [CW-1:0] walk_base, walk_step, ptr_dec, ptr_dec2, count_dec;
  logic          walk_more, match, idx_gt, idx_ge;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // shared walk unit: one incrementer, the pointer and count decrementers and the compares
  assign walk_base = (state == S_RD) ? CW'(idx) : ptr;
  assign walk_step = CW'(walk_base + 1'b1);
  assign walk_more = (walk_step < count);
  assign ptr_dec   = CW'(ptr - 1'b1);
  assign ptr_dec2  = CW'(ptr - 2'd2);
  assign count_dec = CW'(count - 1'b1);
  assign match     = (rd_data == val);
  assign idx_gt    = (idx > CMPW'(count));
  assign idx_ge    = (idx >= CMPW'(count));

  always_comb begin
    state_next      = state;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = rd_data;
    ptr_next        = ptr;
    count_next      = count;
    res_status_next = res_status;
    res_data_next   = res_data;
    res_pos_next    = res_pos;
    res_found_next  = res_found;
    out_load        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_OK;
          res_data_next   = '0;
          res_pos_next    = '0;
          res_found_next  = 1'b0;
          state_next      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        unique case (op)
          OP_INSERT: begin
            if (idx_gt) begin
              res_status_next = ST_BAD_INDEX;
            end else if (count == CW'(DEPTH)) begin
              res_status_next = ST_FULL;
            end else begin
              ptr_next   = count;
              state_next = S_UP;
              if (CMPW'(count) != idx) begin
                rd_en   = 1'b1;
                rd_addr = count_dec[AW-1:0];
              end
            end
          end
          OP_READ, OP_REMOVE: begin
            if (idx_ge) begin
              res_status_next = ST_BAD_INDEX;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = idx[AW-1:0];
              state_next = S_RD;
            end
          end
          OP_OVERWRITE: begin
            if (idx_ge) begin
              res_status_next = ST_BAD_INDEX;
            end else begin
              wr_en   = 1'b1;
              wr_addr = idx[AW-1:0];
              wr_data = val;
            end
          end
          OP_FIND, OP_REMOVE_V: begin
            if (count == '0) begin
              res_status_next = ST_NOT_FOUND;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              ptr_next   = '0;
              state_next = S_SRCH;
            end
          end
          default: begin
            // unused codes change nothing
          end
        endcase
      end
      S_RD: begin
        res_data_next = rd_data;
        if (op == OP_REMOVE) begin
          if (walk_more) begin
            rd_en      = 1'b1;
            rd_addr    = walk_step[AW-1:0];
            ptr_next   = walk_step;
            state_next = S_DOWN;
          end else begin
            count_next = CW'(count - 1'b1);
            state_next = S_DONE;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_UP: begin
        wr_en   = 1'b1;
        wr_addr = ptr[AW-1:0];
        if (CMPW'(ptr) == idx) begin
          wr_data    = val;
          count_next = CW'(count + 1'b1);
          state_next = S_DONE;
        end else begin
          // rd_data holds the entry just below ptr; fetch the next one down
          ptr_next = ptr_dec;
          if (CMPW'(ptr_dec) != idx) begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec2[AW-1:0];
          end
        end
      end
      S_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = ptr_dec[AW-1:0];
        if (walk_more) begin
          rd_en    = 1'b1;
          rd_addr  = walk_step[AW-1:0];
          ptr_next = walk_step;
        end else begin
          count_next = CW'(count - 1'b1);
          state_next = S_DONE;
        end
      end
      S_SRCH: begin
        if (match) begin
          res_found_next = 1'b1;
          res_pos_next   = POS_W'(ptr);
          if (op == OP_REMOVE_V) begin
            res_data_next = val;
            if (walk_more) begin
              rd_en      = 1'b1;
              rd_addr    = walk_step[AW-1:0];
              ptr_next   = walk_step;
              state_next = S_DOWN;
            end else begin
              count_next = CW'(count - 1'b1);
              state_next = S_DONE;
            end
          end else begin
            state_next = S_DONE;
          end
        end else if (walk_more) begin
          rd_en    = 1'b1;
          rd_addr  = walk_step[AW-1:0];
          ptr_next = walk_step;
        end else begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // entry RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.data.operation;
      idx <= CMPW'(req.data.index);
      val <= WIDTH'(req.data.value);
    end
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    res_pos    <= res_pos_next;
    res_found  <= res_found_next;
    if (out_load) begin
      rsp.data.status    <= res_status;
      rsp.data.data      <= VAL_W'(res_data);
      rsp.data.position  <= res_pos;
      rsp.data.found     <= res_found;
      rsp.data.count     <= CNT_W'(count);
      rsp.data.empty_res <= (count == '0);
      rsp.data.full_res  <= (count == CW'(DEPTH));
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == CW'($past(count) + 1'b1) || count == CW'($past(count) - 1'b1)))
    else $error("element count moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.status == ST_FULL) |-> rsp.data.full_res)
    else $error("full status reported on a store that is not full");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.found) |-> (rsp.data.status == ST_OK))
    else $error("found flag set on a failed operation");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for indexed_list_insert_remove_unit
// Drives list operations over the request stream, tracks a shadow copy of the
// list to predict every response, and checks each response transfer against
// the oldest prediction while both sides idle and stall, mostly at random.
// ----------------------------------------------------------------------------
module tb_top;
  import ilist_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 40;

  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;
  localparam int RX_SPARSE  = 3;

  localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

  logic clk;
  logic rst;

  ilist_stream_if #(.T(req_t)) req_ch ();
  ilist_stream_if #(.T(rsp_t)) rsp_ch ();

  indexed_list_insert_remove_unit #(
    .DEPTH(LIST_DEPTH),
    .WIDTH(VAL_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow copy of the list contents
  logic [VAL_W-1:0] shadow_list [LIST_DEPTH];
  int               shadow_count;
  rsp_t             pending_rsp [$];
  int               err_count;

  // sender and receiver pacing
  bit               gaps_on;
  int               burst_left;
  int               rx_mode;
  int               hold_req;
  int               hold_left;
  int               pat_cnt;
  int               idle_cnt;
  logic [VAL_W-1:0] value_pool [8];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic req_t mk_req(logic [OP_W-1:0] op, int idx, logic [VAL_W-1:0] val);
    req_t r;
    r.operation = op;
    r.index     = idx[IDX_W-1:0];
    r.value     = val;
    return r;
  endfunction

  // remove one entry and close the hole
  function automatic logic [VAL_W-1:0] list_take(int pos);
    logic [VAL_W-1:0] v;
    v = shadow_list[pos];
    for (int i = pos + 1; i < shadow_count; i++) shadow_list[i-1] = shadow_list[i];
    shadow_count--;
    return v;
  endfunction

  function automatic rsp_t list_predict(req_t r);
    rsp_t o;
    int   idx;
    int   hit;
    o   = '0;
    idx = int'(r.index);
    hit = -1;
    case (r.operation)
      OP_INSERT: begin
        if (idx > shadow_count) o.status = ST_BAD_INDEX;
        else if (shadow_count >= LIST_DEPTH) o.status = ST_FULL;
        else begin
          for (int i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = r.value;
          shadow_count++;
        end
      end
      OP_READ: begin
        if (idx >= shadow_count) o.status = ST_BAD_INDEX;
        else o.data = shadow_list[idx];
      end
      OP_OVERWRITE: begin
        if (idx >= shadow_count) o.status = ST_BAD_INDEX;
        else shadow_list[idx] = r.value;
      end
      OP_REMOVE: begin
        if (idx >= shadow_count) o.status = ST_BAD_INDEX;
        else o.data = list_take(idx);
      end
      OP_FIND, OP_REMOVE_V: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_list[i] == r.value) hit = i;
        end
        if (hit < 0) o.status = ST_NOT_FOUND;
        else begin
          o.found    = 1'b1;
          o.position = hit[POS_W-1:0];
          if (r.operation == OP_REMOVE_V) o.data = list_take(hit);
        end
      end
      default: ;
    endcase
    o.count     = shadow_count[CNT_W-1:0];
    o.empty_res = (shadow_count == 0);
    o.full_res  = (shadow_count == LIST_DEPTH);
    return o;
  endfunction

  // hold the item until it transfers, then record the prediction
  task automatic send_item(req_t r);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(list_predict(r));
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 8);
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return value_pool[$urandom_range(0, 7)];
  endfunction

  function automatic req_t gen_item(int ins_bias);
    req_t r;
    int   top;
    if ($urandom_range(0, 99) < 8) begin
      // noise: any code, any index
      r = mk_req(OP_W'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom());
    end else if ($urandom_range(0, 99) < ins_bias) begin
      r = mk_req(OP_INSERT, $urandom_range(0, shadow_count), pick_value());
    end else begin
      top = (shadow_count > 0) ? shadow_count - 1 : 0;
      r = mk_req(OP_W'($urandom_range(OP_READ, OP_REMOVE_V)), $urandom_range(0, top),
                 pick_value());
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        err_count++;
        $display("%0t: response with no prediction, expected none, actual %h", $time,
                 rsp_ch.data);
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", VAL_W'(want.status), VAL_W'(rsp_ch.data.status));
        check_field("data", want.data, rsp_ch.data.data);
        check_field("position", VAL_W'(want.position), VAL_W'(rsp_ch.data.position));
        check_field("found", VAL_W'(want.found), VAL_W'(rsp_ch.data.found));
        check_field("count", VAL_W'(want.count), VAL_W'(rsp_ch.data.count));
        check_field("empty_res", VAL_W'(want.empty_res), VAL_W'(rsp_ch.data.empty_res));
        check_field("full_res", VAL_W'(want.full_res), VAL_W'(rsp_ch.data.full_res));
      end
    end
  end

  // receiver stall pattern
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      pat_cnt++;
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  rsp_ch.ready <= 1'b1;
          RX_RANDOM:  rsp_ch.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: rsp_ch.ready <= ((pat_cnt % 7) < 5);
          default:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cnt);
      $display("indexed_list_insert_remove_unit verification failed");
      $finish;
    end
  end

  task automatic test_directed_ops();
    send_item(mk_req(OP_READ, 0, 32'h0));
    send_item(mk_req(OP_REMOVE, 0, 32'h0));
    send_item(mk_req(OP_FIND, 0, 32'h0));
    send_item(mk_req(OP_REMOVE_V, 0, 32'h0));
    send_item(mk_req(OP_INSERT, 1, 32'h1234_5678));
    send_item(mk_req(OP_INSERT, 0, 32'h0000_0000));
    send_item(mk_req(OP_INSERT, 1, 32'hFFFF_FFFF));
    send_item(mk_req(OP_INSERT, 0, 32'hA5A5_A5A5));
    send_item(mk_req(OP_INSERT, 1, 32'h5A5A_5A5A));
    send_item(mk_req(OP_READ, 3, 32'h0));
    send_item(mk_req(OP_READ, 4, 32'h0));
    send_item(mk_req(OP_OVERWRITE, 0, 32'h0000_0000));
    // duplicate value: first match wins
    send_item(mk_req(OP_FIND, 0, 32'h0000_0000));
    send_item(mk_req(OP_REMOVE_V, 0, 32'hFFFF_FFFF));
    send_item(mk_req(OP_REMOVE, 0, 32'h0));
    send_item(mk_req(OP_REMOVE, shadow_count - 1, 32'h0));
    send_item(mk_req(OP_OVERWRITE, 31, 32'hFFFF_FFFF));
    send_item(mk_req(OP_UNUSED6, 31, 32'hFFFF_FFFF));
    send_item(mk_req(OP_UNUSED7, 16, 32'h8000_0001));
    send_item(mk_req(OP_READ, 0, 32'h0));
    send_item(mk_req(OP_FIND, 0, 32'hFFFF_FFFF));
    wait_drained();
  endtask

  task automatic test_capacity();
    while (shadow_count < LIST_DEPTH)
      send_item(mk_req(OP_INSERT, $urandom_range(0, shadow_count), pick_value()));
    send_item(mk_req(OP_INSERT, 0, 32'hDEAD_BEEF));
    send_item(mk_req(OP_INSERT, 16, 32'hDEAD_BEEF));
    send_item(mk_req(OP_INSERT, 17, 32'hDEAD_BEEF));
    send_item(mk_req(OP_READ, 15, 32'h0));
    send_item(mk_req(OP_READ, 16, 32'h0));
    send_item(mk_req(OP_FIND, 0, shadow_list[15]));
    send_item(mk_req(OP_REMOVE, 15, 32'h0));
    send_item(mk_req(OP_INSERT, 15, 32'hFFFF_FFFF));
    send_item(mk_req(OP_REMOVE_V, 0, shadow_list[0]));
    while (shadow_count > 0)
      send_item(mk_req(OP_REMOVE, $urandom_range(0, shadow_count - 1), 32'h0));
    send_item(mk_req(OP_REMOVE, 0, 32'h0));
    wait_drained();
  endtask

  task automatic test_random_traffic(int n, int ins_bias, int mode, bit gaps);
    rx_mode = mode;
    gaps_on = gaps;
    repeat (n) send_item(gen_item(ins_bias));
  endtask

  // stall the response side long enough that the input backs up
  task automatic test_backpressure();
    rx_mode  = RX_ALWAYS;
    gaps_on  = 1'b0;
    hold_req = 400;
    repeat (8) send_item(gen_item(60));
    wait_drained();
  endtask

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    shadow_count = 0;
    err_count    = 0;
    gaps_on      = 1'b1;
    burst_left   = 0;
    rx_mode      = RX_RANDOM;
    hold_req     = 0;
    hold_left    = 0;
    pat_cnt      = 0;
    idle_cnt     = 0;
    for (int i = 0; i < LIST_DEPTH; i++) shadow_list[i] = '0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_ops();
    test_capacity();
    test_random_traffic(300, 70, RX_RANDOM, 1'b1);
    test_backpressure();
    test_random_traffic(300, 30, RX_PATTERN, 1'b1);
    test_random_traffic(300, 55, RX_ALWAYS, 1'b0);
    test_random_traffic(250, 80, RX_SPARSE, 1'b1);
    test_random_traffic(250, 40, RX_RANDOM, 1'b1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_rsp.size() == 0)
      $display("indexed_list_insert_remove_unit verification clean");
    else
      $display("indexed_list_insert_remove_unit verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ilist_pkg.sv
hdl/ilist_stream_if.sv
hdl/indexed_list_insert_remove_unit.sv
tb/tb_top.sv
